// ----- sv/ttrs_pkg.sv -----
`timescale 1ns / 1ps

package ttrs_pkg;

  localparam int unsigned RING_FRAMES = 1024;
  localparam int unsigned RING_W      = $clog2(RING_FRAMES);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned STEP_W      = 3;
  localparam int unsigned Q_SHIFT     = 15;

  localparam logic [CNT_W-1:0]  MAX_FRAMES       = CNT_W'(64);
  localparam logic [15:0]       OSC_COEF_RST     = 16'd65422;
  localparam logic [31:0]       OSC_OLDER_RST    = 32'hFFFF_FE28;
  localparam logic signed [31:0] SAMPLE_MAX      = 32'sd32767;
  localparam logic signed [31:0] SAMPLE_MIN      = -32'sd32767;
  localparam logic [CNT_W-1:0]  PERIOD_FRAMES_RST = CNT_W'(64);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_START = 2'd2,
    REQ_STOP  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_TICKS    = 2'd0,
    CFG_PERIOD   = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_COEF     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_WAIT   = 2'd0,
    OP_DECODE = 2'd1,
    OP_MUL    = 2'd2,
    OP_EMIT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CND_ALWAYS = 3'd0,
    CND_IN     = 3'd1,
    CND_FRAMES = 3'd2,
    CND_FREE   = 3'd3,
    CND_MORE   = 3'd4
  } cnd_e;

  typedef struct packed {
    op_e               op;
    cnd_e              cnd;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] alt;
  } ucode_t;

  typedef struct packed {
    logic mul_en;
    logic adv_en;
  } osc_ctrl_t;

  // control store: wait, decode, multiply, emit, multiply-and-loop
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      3'd0:    w = '{op: OP_WAIT,   cnd: CND_IN,     jmp: 3'd1, alt: 3'd0};
      3'd1:    w = '{op: OP_DECODE, cnd: CND_FRAMES, jmp: 3'd2, alt: 3'd0};
      3'd2:    w = '{op: OP_MUL,    cnd: CND_ALWAYS, jmp: 3'd3, alt: 3'd3};
      3'd3:    w = '{op: OP_EMIT,   cnd: CND_FREE,   jmp: 3'd4, alt: 3'd3};
      3'd4:    w = '{op: OP_MUL,    cnd: CND_MORE,   jmp: 3'd3, alt: 3'd0};
      default: w = '{op: OP_WAIT,   cnd: CND_ALWAYS, jmp: 3'd0, alt: 3'd0};
    endcase
    return w;
  endfunction

  function automatic logic [CNT_W-1:0] cap_count(input logic [CNT_W-1:0] n);
    return (n > MAX_FRAMES) ? MAX_FRAMES : n;
  endfunction

endpackage

// ----- sv/ttrs_osc.sv -----
`timescale 1ns / 1ps

module ttrs_osc (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [15:0]             coef_i,
  input  ttrs_pkg::osc_ctrl_t     ctrl_i,
  output logic signed [15:0]      sample_o
);
  import ttrs_pkg::*;

  logic [31:0]        older_q, newer_q;
  logic signed [48:0] prod_q, prod_d;
  logic [31:0]        y2;

  assign prod_d = $signed({1'b0, coef_i}) * $signed(newer_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // floor shift by taking the upper bits, wrap to 32
  assign y2 = prod_q[Q_SHIFT +: 32] - older_q;

  always_comb begin
    if ($signed(y2) > SAMPLE_MAX) begin
      sample_o = SAMPLE_MAX[15:0];
    end else if ($signed(y2) < SAMPLE_MIN) begin
      sample_o = SAMPLE_MIN[15:0];
    end else begin
      sample_o = y2[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= OSC_OLDER_RST;
      newer_q <= '0;
    end else if (ctrl_i.adv_en) begin
      older_q <= newer_q;
      newer_q <= y2;
    end
  end

endmodule

// ----- sv/test_tone_ring_source.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake             words
// cfg      in         cfg_valid/cfg_ready   register index, data
// in       in         in_valid/in_stall     request: type, fill count, write index
// out      out        out_valid/out_stall   one frame: sample, slot, source, last, read index
//
// start, stop, idle ticks and zero-frame requests pass through decode and return to wait
// a request with frames runs decode, a first multiply, then emit and multiply per frame
// the emit step holds while the output register is full and stalled
// reset: oscillator at older -472, newer 0; indices, run flag and countdown cleared
module test_tone_ring_source (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [ttrs_pkg::CNT_W-1:0]   fill_frame_count_i,
  input  logic [ttrs_pkg::RING_W-1:0]  play_write_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [15:0]           sample_o,
  output logic [ttrs_pkg::RING_W-1:0]  frame_index_o,
  output logic                         source_o,
  output logic                         last_o,
  output logic [ttrs_pkg::RING_W-1:0]  play_read_index_o
);
  import ttrs_pkg::*;

  logic [31:0]        tpp_q;
  logic [CNT_W-1:0]   pf_q;
  logic [15:0]        coef_q;

  logic [STEP_W-1:0]  step_q, step_d;
  ucode_t             uw;
  logic               cnd_ok;

  req_e               req_q;
  logic [CNT_W-1:0]   fill_q;
  logic [RING_W-1:0]  wr_q;

  logic               run_q, run_d;
  logic [31:0]        ticks_q, ticks_d;
  logic [RING_W-1:0]  cap_idx_q, cap_idx_d;
  logic [RING_W-1:0]  rd_q, rd_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               src_q, src_d;

  logic [CNT_W-1:0]   pf_cap;
  logic [RING_W-1:0]  avail;
  logic [CNT_W-1:0]   take;
  logic               out_free;
  logic               emit;

  osc_ctrl_t          osc_ctrl;
  logic signed [15:0] osc_sample;

  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic [RING_W-1:0]  frame_index_q, play_read_q;
  logic               source_q, last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpp_q  <= '0;
      pf_q   <= PERIOD_FRAMES_RST;
      coef_q <= OSC_COEF_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TICKS:    tpp_q  <= cfg_data_i;
        CFG_PERIOD:   pf_q   <= cfg_data_i[CNT_W-1:0];
        CFG_CHANNELS: ;  // nothing kept
        CFG_COEF:     coef_q <= cfg_data_i[15:0];
        default:      ;
      endcase
    end
  end

  assign uw         = ucode_rom(step_q);
  assign in_stall_o = (uw.op != OP_WAIT);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (uw.op == OP_EMIT) && out_free;

  always_ff @(posedge clk_i) begin
    if (uw.op == OP_WAIT && in_valid_i) begin
      req_q  <= req_e'(req_type_i);
      fill_q <= fill_frame_count_i;
      wr_q   <= play_write_index_i;
    end
  end

  assign pf_cap = cap_count(pf_q);
  assign avail  = wr_q - rd_q;
  assign take   = (avail < RING_W'(pf_cap)) ? avail[CNT_W-1:0] : pf_cap;

  always_comb begin
    run_d     = run_q;
    ticks_d   = ticks_q;
    cap_idx_d = cap_idx_q;
    rd_d      = rd_q;
    count_d   = count_q;
    src_d     = src_q;
    if (uw.op == OP_DECODE) begin
      count_d = '0;
      unique case (req_q)
        REQ_START: begin
          run_d   = 1'b1;
          ticks_d = tpp_q;
        end
        REQ_STOP: begin
          run_d = 1'b0;
        end
        REQ_FILL: begin
          count_d = cap_count(fill_q);
          src_d   = 1'b0;
        end
        REQ_TICK: begin
          if (run_q) begin
            if (ticks_q > 32'd1) begin
              ticks_d = ticks_q - 32'd1;
            end else begin
              ticks_d = tpp_q;
              count_d = pf_cap;
              src_d   = 1'b1;
              rd_d    = rd_q + RING_W'(take);
            end
          end
        end
        default: ;
      endcase
    end else if (emit) begin
      count_d   = count_q - CNT_W'(1);
      cap_idx_d = cap_idx_q + RING_W'(1);
    end
  end

  always_comb begin
    unique case (uw.cnd)
      CND_ALWAYS: cnd_ok = 1'b1;
      CND_IN:     cnd_ok = in_valid_i;
      CND_FRAMES: cnd_ok = (count_d != '0);
      CND_FREE:   cnd_ok = out_free;
      CND_MORE:   cnd_ok = (count_q != '0);
      default:    cnd_ok = 1'b0;
    endcase
    step_d = cnd_ok ? uw.jmp : uw.alt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      run_q     <= 1'b0;
      ticks_q   <= '0;
      cap_idx_q <= '0;
      rd_q      <= '0;
      count_q   <= '0;
      src_q     <= 1'b0;
    end else begin
      step_q    <= step_d;
      run_q     <= run_d;
      ticks_q   <= ticks_d;
      cap_idx_q <= cap_idx_d;
      rd_q      <= rd_d;
      count_q   <= count_d;
      src_q     <= src_d;
    end
  end

  assign osc_ctrl.mul_en = (uw.op == OP_MUL);
  assign osc_ctrl.adv_en = emit;

  ttrs_osc u_osc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_i   (coef_q),
    .ctrl_i   (osc_ctrl),
    .sample_o (osc_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sample_q      <= osc_sample;
      frame_index_q <= cap_idx_q;
      source_q      <= src_q;
      last_q        <= (count_q == CNT_W'(1));
      play_read_q   <= rd_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_o          = sample_q;
  assign frame_index_o     = frame_index_q;
  assign source_o          = source_q;
  assign last_o            = last_q;
  assign play_read_index_o = play_read_q;

endmodule
